>>> sv/lmsb_pkg.sv
// ----------------------------------------------------------------------------
// lmsb_pkg: shared types and constants
// Input and result word layouts, opcodes, register indexes and the queue
// entry passed from the front end to the back end.
// ----------------------------------------------------------------------------
package lmsb_pkg;

  localparam int PIX_W = 8;
  localparam int DIM_W = 11;
  localparam int RAD_W = 4;
  localparam int K_W   = 16;
  localparam int CFG_W = 16;
  localparam int IDX_W = 3;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_HX     = 3'd2,
    REG_HY     = 3'd3,
    REG_K      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] pixel_value;
  } in_word_t;

  typedef struct packed {
    logic pixel_on;
    logic frame_last;
  } out_word_t;

  // front end to back end: a pixel to store and/or a result to produce
  typedef struct packed {
    logic        wr;
    logic [9:0]  wcol;
    logic [10:0] wrow;
    logic [7:0]  wval;
    logic        ev;
    logic [9:0]  ocol;
    logic [10:0] orow;
    logic        last;
  } job_t;

  // back end state machine
  typedef enum logic [2:0] {
    BE_IDLE,
    BE_READ,
    BE_ACC,
    BE_DIV,
    BE_SQRT,
    BE_CMP,
    BE_OUT
  } be_state_t;

endpackage

>>> sv/lmsb_if.sv
// ----------------------------------------------------------------------------
// lmsb_if: valid/ready stream channel
// Carries one word of type T between a source and a sink.
// ----------------------------------------------------------------------------
interface lmsb_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/lmsb_front.sv
// ----------------------------------------------------------------------------
// lmsb_front: position tracking and classification
// Counts input and output raster positions, decides for each accepted word
// whether it stores a pixel and whether it releases a result.
// ----------------------------------------------------------------------------
module lmsb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                restart,
  input  logic [10:0]         w,
  input  logic [10:0]         h,
  input  logic [3:0]          hx,
  input  logic [3:0]          hy,
  input  logic                in_valid,
  output logic                in_ready,
  input  lmsb_pkg::in_word_t  in_data,
  output logic                q_push,
  input  logic                q_full,
  output lmsb_pkg::job_t      q_data
);
  import lmsb_pkg::*;

  logic [9:0]  icol, ocol;
  logic [10:0] irow, orow;
  logic        idone;
  logic [20:0] recv, emit, lag, total;
  logic        wr, ev, last, acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  // counts in raster order
  always_comb begin
    total = 21'(w) * 21'(h);
    recv  = idone ? total : 21'(irow) * 21'(w) + 21'(icol);
    emit  = 21'(orow) * 21'(w) + 21'(ocol);
    lag   = 21'(hy) * 21'(w) + 21'(hx);
    wr    = (in_data.opcode == OP_PIXEL) && !idone;
    // received after this word's store
    ev    = idone || (recv + 21'(wr) >= emit + lag + 21'd1) ||
            (wr && ({1'b0, icol} == w - 11'd1) && (irow == h - 11'd1));
    last  = (orow == h - 11'd1) && ({1'b0, ocol} == w - 11'd1);
  end

  assign q_push = acc && (wr || ev);
  always_comb begin
    q_data      = '0;
    q_data.wr   = wr;
    q_data.wcol = icol;
    q_data.wrow = irow;
    q_data.wval = in_data.pixel_value;
    q_data.ev   = ev;
    q_data.ocol = ocol;
    q_data.orow = orow;
    q_data.last = last;
  end

  // position registers
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      icol  <= '0;
      irow  <= '0;
      ocol  <= '0;
      orow  <= '0;
      idone <= 1'b0;
    end else if (acc) begin
      if (ev && last) begin
        icol  <= '0;
        irow  <= '0;
        ocol  <= '0;
        orow  <= '0;
        idone <= 1'b0;
      end else begin
        if (wr) begin
          if ({1'b0, icol} == w - 11'd1) begin
            icol <= '0;
            if (irow == h - 11'd1) begin
              irow  <= '0;
              idone <= 1'b1;
            end else begin
              irow <= irow + 11'd1;
            end
          end else begin
            icol <= icol + 10'd1;
          end
        end
        if (ev) begin
          if ({1'b0, ocol} == w - 11'd1) begin
            ocol <= '0;
            orow <= orow + 11'd1;
          end else begin
            ocol <= ocol + 10'd1;
          end
        end
      end
    end
  end
endmodule

>>> sv/lmsb_queue.sv
// ----------------------------------------------------------------------------
// lmsb_queue: short job queue
// Four-entry fifo decoupling classification from evaluation.
// ----------------------------------------------------------------------------
module lmsb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           flush,
  input  logic           push,
  input  lmsb_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output lmsb_pkg::job_t pop_data
);
  import lmsb_pkg::*;

  job_t       mem [4];
  logic [1:0] rp, wp;
  logic [2:0] cnt;

  assign full     = cnt == 3'd4;
  assign empty    = cnt == 3'd0;
  assign pop_data = mem[rp];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      rp  <= '0;
      wp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop) rp <= rp + 2'd1;
      cnt <= cnt + 3'(push) - 3'(pop);
    end
  end
endmodule

>>> sv/lmsb_back.sv
// ----------------------------------------------------------------------------
// lmsb_back: window evaluation
// Stores pixels in the line ring, sums the clipped window one pixel a
// cycle, then divides, takes the square root and compares, bit-serially.
// ----------------------------------------------------------------------------
module lmsb_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                flush,
  input  logic [10:0]         w,
  input  logic [10:0]         h,
  input  logic [3:0]          hx,
  input  logic [3:0]          hy,
  input  logic signed [15:0]  k,
  input  logic                q_empty,
  input  lmsb_pkg::job_t      q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output lmsb_pkg::out_word_t out_data
);
  import lmsb_pkg::*;

  localparam int RING = 32;

  logic [7:0]  ram [RING*1024];
  logic [7:0]  rd;
  be_state_t   state, state_next;
  job_t        job;
  logic [10:0] r0, r1, r;
  logic [9:0]  c0, c1, c;
  logic [9:0]  tc;
  logic [17:0] s;
  logic [25:0] qq;
  logic [7:0]  p;
  logic        have_p;
  logic        rd_ok;
  logic [4:0]  ring_r;
  // divider
  logic [25:0] dnum, dq;
  logic [25:0] drem;
  logic [5:0]  step;
  logic        dphase;
  logic [17:0] mean8;
  logic [25:0] std8;
  // square root
  logic [63:0] var_v;
  logic [35:0] root;
  logic [37:0] rem;
  logic [37:0] rtrial;
  logic        pon;

  // ring row of a frame row
  function automatic logic [4:0] ring_of(input logic [10:0] row);
    ring_of = row[4:0];
  endfunction

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (state == BE_IDLE && !q_empty && q_data.wr) begin
      ram[{ring_of(q_data.wrow), q_data.wcol}] <= q_data.wval;
    end
    rd <= ram[{ring_r, c}];
  end
  assign ring_r = ring_of(r);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BE_IDLE: if (!q_empty && q_data.ev) state_next = BE_READ;
      BE_READ: state_next = BE_ACC;
      BE_ACC:  if (have_p && rd_ok) state_next = BE_DIV;
      BE_DIV:  if (step == 6'd25) state_next = dphase ? BE_CMP : BE_SQRT;
      BE_SQRT: if (step == 6'd39) state_next = BE_DIV;
      BE_CMP:  state_next = BE_OUT;
      BE_OUT:  if (out_ready) state_next = BE_IDLE;
      default: state_next = BE_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop              = (state == BE_IDLE) && !q_empty;
    out_valid          = state == BE_OUT;
    out_data.pixel_on  = pon;
    out_data.frame_last = job.last;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      state <= BE_IDLE;
    end else begin
      state <= state_next;
      case (state)
        BE_IDLE: begin
          job <= q_data;
          r0 <= (q_data.orow > 11'(hy)) ? q_data.orow - 11'(hy) : '0;
          r1 <= (q_data.orow + 11'(hy) < h) ? q_data.orow + 11'(hy) : h - 11'd1;
          c0 <= ({1'b0, q_data.ocol} > 11'(hx)) ? q_data.ocol - 10'(hx) : '0;
          c1 <= ({1'b0, q_data.ocol} + 11'(hx) < w) ? q_data.ocol + 10'(hx)
                                                     : 10'(w - 11'd1);
          r <= q_data.orow;
          c <= q_data.ocol;
          have_p <= 1'b0;
        end
        BE_READ: begin
          r <= r0;
          c <= c0;
          rd_ok <= 1'b0;
          s <= '0;
          qq <= '0;
          tc <= '0;
        end
        BE_ACC: begin
          // first read is the centre pixel, then one window pixel a cycle
          rd_ok <= (r == r1) && (c == c1);
          if (!have_p) begin
            p <= rd;
            have_p <= 1'b1;
          end else begin
            s <= s + 18'(rd);
            qq <= qq + 26'(rd) * 26'(rd);
            tc <= tc + 10'd1;
          end
          if (have_p && rd_ok) begin
            step <= '0;
            dphase <= 1'b0;
            dnum <= {s + 18'(rd), 8'd0};
            drem <= '0;
            dq <= '0;
          end
          // walk the window column by column, holding at the last pixel
          if (r != r1) begin
            r <= r + 11'd1;
          end else if (c != c1) begin
            r <= r0;
            c <= c + 10'd1;
          end
        end
        BE_DIV: begin
          // restoring division by the pixel count, one bit a cycle
          if (step == 6'd25 && !dphase) begin
            mean8 <= 18'({dq[24:0], ~({drem[24:0], dnum[25]} < 26'(tc))});
            step <= '0;
            root <= '0;
            rem <= '0;
            var_v <= {28'd0, 36'(tc) * 36'(qq) - 36'(s) * 36'(s)};
          end else if (step == 6'd25) begin
            std8 <= 26'({dq[24:0], ~({drem[24:0], dnum[25]} < 26'(tc))});
          end else begin
            if ({drem[24:0], dnum[25]} >= 26'(tc)) begin
              drem <= {drem[24:0], dnum[25]} - 26'(tc);
              dq <= {dq[24:0], 1'b1};
            end else begin
              drem <= {drem[24:0], dnum[25]};
              dq <= {dq[24:0], 1'b0};
            end
            dnum <= {dnum[24:0], 1'b0};
            step <= step + 6'd1;
          end
        end
        BE_SQRT: begin
          // one root digit a cycle
          if ({rem[35:0], var_v[63:62]} >= 38'(rtrial)) begin
            rem <= {rem[35:0], var_v[63:62]} - 38'(rtrial);
            root <= {root[34:0], 1'b1};
          end else begin
            rem <= {rem[35:0], var_v[63:62]};
            root <= {root[34:0], 1'b0};
          end
          var_v <= {var_v[61:0], 2'b00};
          if (step == 6'd39) begin
            // root stays below 2^26, so it fits the dividend
            dphase <= 1'b1;
            step <= '0;
            dnum <= {root[24:0], ({rem[35:0], var_v[63:62]} >= 38'(rtrial))};
            drem <= '0;
            dq <= '0;
          end else begin
            step <= step + 6'd1;
          end
        end
        BE_CMP: begin
          pon <= ($signed({1'b0, p, 20'd0}) >
                  $signed({1'b0, mean8, 12'd0}) + 48'(k) * $signed({1'b0, std8}));
        end
        default: ;
      endcase
    end
  end
  assign rtrial = {root, 2'b01};
endmodule

>>> sv/local_mean_std_binarizer.sv
// ----------------------------------------------------------------------------
// local_mean_std_binarizer: local mean and deviation thresholding
// Raster pixels in, one binary word out per pixel after a lag of
// hy*width+hx pixels; drain words flush the end of the frame.
// ----------------------------------------------------------------------------
// evaluation: one result at a time; the back end sums the window through the single
// ram read port and runs the bit-serial divider and square root before it takes
// the next job from the queue
// reset: synchronous, positions cleared, registers to defaults; any
// register write restarts the frame
module local_mean_std_binarizer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lmsb_pkg::IDX_W-1:0] cfg_index,
  input  logic [lmsb_pkg::CFG_W-1:0] cfg_data,
  lmsb_if.sink                       in_ch,
  lmsb_if.source                     out_ch
);
  import lmsb_pkg::*;

  logic [10:0] image_width, image_height, w, h;
  logic [3:0]  half_window_x, half_window_y, hx, hy;
  logic [15:0] k_scaled;
  logic        restart, q_push, q_full, q_pop, q_empty;
  job_t        qin, qout;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 11'd640;
      image_height  <= 11'd480;
      half_window_x <= 4'd7;
      half_window_y <= 4'd7;
      k_scaled      <= 16'hFE66;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_WIDTH:  image_width   <= cfg_data[10:0];
        REG_HEIGHT: image_height  <= cfg_data[10:0];
        REG_HX:     half_window_x <= cfg_data[3:0];
        REG_HY:     half_window_y <= cfg_data[3:0];
        REG_K:      k_scaled      <= cfg_data;
        default: ;
      endcase
    end
  end
  assign restart = cfg_we && (cfg_index <= IDX_W'(REG_K));

  // effective geometry
  always_comb begin
    w  = (image_width == 0) ? 11'd1 : (image_width > 11'd1024 ? 11'd1024 : image_width);
    h  = (image_height == 0) ? 11'd1 : (image_height > 11'd1024 ? 11'd1024 : image_height);
    hx = (11'(half_window_x) > w - 11'd1) ? 4'(w - 11'd1) : half_window_x;
    hy = (11'(half_window_y) > h - 11'd1) ? 4'(h - 11'd1) : half_window_y;
  end

  lmsb_front u_front (
    .clk, .rst, .restart, .w, .h, .hx, .hy,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_push, .q_full, .q_data(qin)
  );

  lmsb_queue u_queue (
    .clk, .rst, .flush(restart), .push(q_push), .push_data(qin), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_data(qout)
  );

  lmsb_back u_back (
    .clk, .rst, .flush(restart), .w, .h, .hx, .hy, .k(k_scaled),
    .q_empty, .q_data(qout), .q_pop,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule

>>> sv/lmsb_checker.sv
// ----------------------------------------------------------------------------
// lmsb_checker: port-level checks
// Watches the result channel and configuration port of the top level.
// ----------------------------------------------------------------------------
module lmsb_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_we,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_data
);
  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && !$past(cfg_we) && !cfg_we |=> out_valid)
    else $error("result dropped while stalled");

  // no result right after reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result after reset");

  // stalled payload stable
  a_stable: assert property (@(posedge clk) disable iff (rst || cfg_we)
    $past(out_valid && !out_ready) && out_valid |-> $stable(out_data))
    else $error("result changed while stalled");
endmodule

bind local_mean_std_binarizer lmsb_checker u_chk (
  .clk, .rst, .cfg_we,
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

>>> tb/lmsb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lmsb_scoreboard: binarizer scoreboard
// Watches the register port and both word channels, keeps its own copy of
// the frame geometry, line store and positions, works out the binary word
// owed, if any, for each accepted input word and compares it with the output words.
// ----------------------------------------------------------------------------
module lmsb_scoreboard (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lmsb_pkg::IDX_W-1:0] cfg_index,
  input  logic [lmsb_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  lmsb_pkg::in_word_t         in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  lmsb_pkg::out_word_t        out_data,
  output int                         fail_count,
  output int                         pending
);
  import lmsb_pkg::*;

  localparam int LINE_LEN   = 1024;
  localparam int RING_LINES = 32;
  localparam int HALF_MAX   = 15;

  // register copies
  logic [10:0] width_reg, height_reg;
  logic [3:0]  rad_x_reg, rad_y_reg;
  logic [15:0] k_reg;

  // clipped geometry
  int eff_w, eff_h, eff_rx, eff_ry;

  logic [7:0] grey_ring [RING_LINES*LINE_LEN];
  int         wr_col, wr_row, rd_col, rd_row;
  bit         frame_in;
  out_word_t  owed_words [$];

  function automatic longint unsigned root_of(input longint unsigned x);
    longint unsigned r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  task automatic clip_geometry();
    eff_w  = (width_reg == 0) ? 1 : (width_reg > LINE_LEN ? LINE_LEN : width_reg);
    eff_h  = (height_reg == 0) ? 1 : (height_reg > 1024 ? 1024 : height_reg);
    eff_rx = (rad_x_reg > eff_w - 1) ? eff_w - 1 : rad_x_reg;
    eff_ry = (rad_y_reg > eff_h - 1) ? eff_h - 1 : rad_y_reg;
  endtask

  // local threshold decision for one position
  function automatic bit above_threshold(input int orow, input int ocol);
    int r0, r1, c0, c1;
    longint unsigned cnt, s, q, v, var_n, mean8, std8;
    longint lhs, rhs, kk;
    r0 = (orow > eff_ry) ? orow - eff_ry : 0;
    r1 = (orow + eff_ry < eff_h) ? orow + eff_ry : eff_h - 1;
    c0 = (ocol > eff_rx) ? ocol - eff_rx : 0;
    c1 = (ocol + eff_rx < eff_w) ? ocol + eff_rx : eff_w - 1;
    cnt = longint'(r1 - r0 + 1) * longint'(c1 - c0 + 1);
    s = 0;
    q = 0;
    for (int r = r0; r <= r1; r++)
      for (int c = c0; c <= c1; c++) begin
        v = grey_ring[(r % RING_LINES) * LINE_LEN + c];
        s += v;
        q += v * v;
      end
    mean8 = (s << 8) / cnt;
    var_n = cnt * q - s * s;
    std8  = root_of(var_n << 16) / cnt;
    kk  = longint'($signed(k_reg));
    lhs = longint'(grey_ring[(orow % RING_LINES) * LINE_LEN + ocol]) <<< 20;
    rhs = longint'(mean8 << 12) + kk * longint'(std8);
    return lhs > rhs;
  endfunction

  task automatic restart_frame();
    wr_col = 0;
    wr_row = 0;
    rd_col = 0;
    rd_row = 0;
    frame_in = 0;
  endtask

  // one accepted input word: store it, then see whether a result is due
  task automatic take_word(input in_word_t w);
    longint total, seen, done_cnt, lag;
    out_word_t res;
    clip_geometry();
    if (w.opcode == OP_PIXEL && !frame_in) begin
      grey_ring[(wr_row % RING_LINES) * LINE_LEN + wr_col] = w.pixel_value;
      wr_col++;
      if (wr_col >= eff_w) begin
        wr_col = 0;
        wr_row++;
        if (wr_row >= eff_h) begin
          wr_row = 0;
          frame_in = 1;
        end
      end
    end
    total    = longint'(eff_w) * eff_h;
    seen     = frame_in ? total : longint'(wr_row) * eff_w + wr_col;
    done_cnt = longint'(rd_row) * eff_w + rd_col;
    lag      = longint'(eff_ry) * eff_w + eff_rx;
    if (done_cnt >= total) return;
    if (!frame_in && seen < done_cnt + lag + 1) return;
    res.pixel_on   = above_threshold(rd_row, rd_col);
    res.frame_last = (rd_row == eff_h - 1 && rd_col == eff_w - 1);
    owed_words.push_back(res);
    if (res.frame_last) begin
      restart_frame();
    end else begin
      rd_col++;
      if (rd_col >= eff_w) begin
        rd_col = 0;
        rd_row++;
      end
    end
  endtask

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst) begin
      width_reg  = 11'd640;
      height_reg = 11'd480;
      rad_x_reg  = 4'd7;
      rad_y_reg  = 4'd7;
      k_reg      = 16'hFE66;
      fail_count <= 0;
      pending    <= 0;
      owed_words.delete();
      restart_frame();
    end else begin
      // register writes restart the frame
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_WIDTH:  width_reg  = cfg_data[10:0];
          REG_HEIGHT: height_reg = cfg_data[10:0];
          REG_HX:     rad_x_reg  = cfg_data[3:0];
          REG_HY:     rad_y_reg  = cfg_data[3:0];
          REG_K:      k_reg      = cfg_data;
          default: ;
        endcase
        if (cfg_index <= REG_K) restart_frame();
      end
      // output word against the oldest owed word
      if (out_valid && out_ready) begin
        if (owed_words.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected output word on=%0d last=%0d", $realtime,
                     out_data.pixel_on, out_data.frame_last);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = owed_words.pop_front();
          if (exp_w.pixel_on !== out_data.pixel_on ||
              exp_w.frame_last !== out_data.frame_last) begin
            if (fail_count < 10)
              $display("%0t: mismatch on=%0d/%0d last=%0d/%0d (expected/actual)",
                       $realtime, exp_w.pixel_on, out_data.pixel_on,
                       exp_w.frame_last, out_data.frame_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) take_word(in_data);
      pending <= owed_words.size();
    end
  end

endmodule

>>> tb/local_mean_std_binarizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// local_mean_std_binarizer_tb: binarizer testbench
// Writes frame geometry and k, streams directed and random frames with
// drains and noise under varying back pressure, and leaves comparison to
// the checker; prints the verdict.
// ----------------------------------------------------------------------------
module local_mean_std_binarizer_tb;
  import lmsb_pkg::*;

  localparam int STALL_LIMIT = 50000;
  localparam int HOLD_OFF    = 2200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  int fail_count, pending;
  int tx_idle_pct = 0, rx_idle_pct = 0;
  int words_sent = 0, stall_cycles = 0;
  int cur_w, cur_h, cur_rx, cur_ry;
  int reg_h = 480, reg_rx = 7, reg_ry = 7;

  lmsb_if #(.T(in_word_t))  in_ch ();
  lmsb_if #(.T(out_word_t)) out_ch ();

  local_mean_std_binarizer u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  lmsb_scoreboard u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always #10 clk = ~clk;

  // receiver back pressure
  always @(posedge clk) begin
    if (rst)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_word(input opcode_t op, input logic [7:0] val);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{opcode: op, pixel_value: val};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // stop sending until every owed word is out and the back end is quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    @(posedge clk);
  endtask

  // write the geometry; all registers or a random subset (width always)
  task automatic set_geometry(input int w, input int h, input int rx, input int ry,
                              input int k, input bit all_regs);
    write_reg(REG_WIDTH, w);
    if (all_regs || $urandom_range(1)) begin
      write_reg(REG_HEIGHT, h);
      reg_h = h;
    end else h = reg_h;
    if (all_regs || $urandom_range(1)) begin
      write_reg(REG_HX, rx);
      reg_rx = rx;
    end else rx = reg_rx;
    if (all_regs || $urandom_range(1)) begin
      write_reg(REG_HY, ry);
      reg_ry = ry;
    end else ry = reg_ry;
    if (all_regs || $urandom_range(1)) write_reg(REG_K, k);
    cfg_we <= 1'b0;
    cur_w  = (w == 0) ? 1 : (w > 1024 ? 1024 : w);
    cur_h  = (h == 0) ? 1 : (h > 1024 ? 1024 : h);
    cur_rx = (rx > cur_w - 1) ? cur_w - 1 : rx;
    cur_ry = (ry > cur_h - 1) ? cur_h - 1 : ry;
  endtask

  task automatic run_frame(input bit abort, input bit noisy);
    int total, cut, lag, style;
    logic [7:0] flat, val;
    total = cur_w * cur_h;
    lag   = cur_ry * cur_w + cur_rx;
    cut   = abort ? $urandom_range(total - 1) : total;
    style = $urandom_range(3);
    flat  = 8'($urandom_range(255));
    for (int i = 0; i < cut; i++) begin
      if (noisy && $urandom_range(99) < 8) push_word(OP_DRAIN, 8'($urandom_range(255)));
      case (style)
        0: val = flat;
        1: val = $urandom_range(1) ? 8'd255 : 8'd0;
        default: val = 8'($urandom_range(255));
      endcase
      push_word(OP_PIXEL, val);
    end
    if (abort) return;
    // flush; a pixel after a complete frame also drains
    for (int i = 0; i < lag; i++) begin
      if (noisy && $urandom_range(99) < 15) push_word(OP_PIXEL, 8'($urandom_range(255)));
      else push_word(OP_DRAIN, 8'($urandom_range(255)));
    end
    if (noisy && $urandom_range(99) < 20) push_word(OP_DRAIN, 8'h00);
  endtask

  initial begin
    int k;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 3x3 frame, radius 1, k zero
    set_geometry(3, 3, 1, 1, 0, 1);
    push_word(OP_DRAIN, 8'hFF);
    push_word(OP_PIXEL, 8'h00);
    push_word(OP_PIXEL, 8'hFF);
    push_word(OP_PIXEL, 8'h55);
    push_word(OP_PIXEL, 8'hAA);
    settle();
    push_word(OP_PIXEL, 8'h0F);
    push_word(OP_PIXEL, 8'hF0);
    push_word(OP_PIXEL, 8'hFF);
    push_word(OP_PIXEL, 8'h00);
    push_word(OP_PIXEL, 8'h80);
    push_word(OP_PIXEL, 8'h01);
    push_word(OP_DRAIN, 8'h00);
    push_word(OP_DRAIN, 8'h00);
    push_word(OP_DRAIN, 8'h00);
    push_word(OP_DRAIN, 8'h00);
    settle();

    // zero sizes and radius beyond the frame
    set_geometry(0, 0, 15, 15, 32767, 1);
    run_frame(0, 0);
    settle();
    set_geometry(2, 3, 15, 1, -32768, 1);
    run_frame(0, 1);
    settle();

    // random frames under three idling regimes
    while (words_sent < 440) begin
      if (words_sent < 150) begin
        tx_idle_pct = 25;
        rx_idle_pct = 86;
      end else if (words_sent < 300) begin
        tx_idle_pct = 86;
        rx_idle_pct = 25;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case ($urandom_range(7))
        0: k = -32768;
        1: k = 32767;
        default: k = $urandom_range(65535);
      endcase
      set_geometry($urandom_range(12), $urandom_range(8), $urandom_range(15),
                   $urandom_range(15), k, 0);
      repeat ($urandom_range(1, 2)) run_frame($urandom_range(99) < 10, 1);
      settle();
    end

    // widest and tallest frames, saturating sizes; the start of each only
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_geometry(2047, 1, 15, 15, -32768, 1);
    repeat (60) push_word(OP_PIXEL, 8'($urandom_range(255)));
    settle();
    set_geometry(1, 2047, 15, 15, 32767, 1);
    repeat (60) push_word(OP_PIXEL, 8'($urandom_range(255)));

    settle();
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
